// ===== rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver package
// Shared types, codes and constants for the serial frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // Command codes carried with each input transaction.
  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  // Configuration port layout.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_MATCH_ID   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_START_BYTE = 2'd1;

  localparam logic [15:0] MATCH_ID_RESET   = 16'h0040;
  localparam logic [7:0]  START_BYTE_RESET = 8'hAA;

  // Smallest payload that carries buttons and both view bytes.
  localparam logic [3:0] MIN_LATCH_LEN = 4'd4;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_ACCEPTED  = 3'd1,
    ST_CHECK_ERR = 3'd2,
    ST_LEN_ERR   = 3'd3,
    ST_IGNORED   = 3'd4,
    ST_TIMEOUT   = 3'd5
  } status_e;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        buttons;
    logic signed [7:0]  view_x;
    logic signed [7:0]  view_y;
    status_e            status;
  } out_item_t;

endpackage

// ===== rtl/sfr_in_if.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver input channel
// Valid/ready channel that carries received bytes and timeout events.
// ----------------------------------------------------------------------------
interface sfr_in_if import sfr_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/sfr_out_if.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver output channel
// Valid/ready channel that carries the latched values and a status.
// ----------------------------------------------------------------------------
interface sfr_out_if import sfr_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/sfr_in_stage.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver input register
// Holds one accepted transaction until the parser consumes it.
// ----------------------------------------------------------------------------
module sfr_in_stage import sfr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  sfr_in_if.sink   in_ch,
  input  logic     advance_i,
  output logic     valid_o,
  output in_item_t item_o
);

  logic     valid_q;
  in_item_t item_q;

  // A held item leaving this cycle frees the register for the next one.
  assign in_ch.ready = !valid_q || advance_i;
  assign valid_o     = valid_q;
  assign item_o      = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      item_q <= in_ch.data;
    end
  end

endmodule

// ===== rtl/sfr_parser.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver parser
// Frame state machine, XOR check, latched outputs and configuration registers.
// ----------------------------------------------------------------------------
module sfr_parser import sfr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  in_item_t            item_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output out_item_t           result_o
);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_ID_LO   = 3'd1,
    PH_ID_HI   = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_SEQ     = 3'd5,
    PH_CHECK   = 3'd6
  } phase_e;

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  phase_e          phase_q, phase_d;
  logic [3:0]      count_q, count_d;
  logic [3:0]      len_q, len_d;
  logic [15:0]     id_q, id_d;
  logic [7:0]      check_q, check_d;
  logic [3:0][7:0] head_q, head_d;
  logic [15:0]     buttons_q, buttons_d;
  logic [7:0]      view_x_q, view_x_d;
  logic [7:0]      view_y_q, view_y_d;
  logic [15:0]     match_id_q;
  logic [7:0]      start_byte_q;

  status_e         status;
  logic [7:0]      rx;
  logic [3:0]      count_inc;

  assign rx        = item_i.rx_byte;
  assign count_inc = count_q + 4'd1;

  always_comb begin
    phase_d   = phase_q;
    count_d   = count_q;
    len_d     = len_q;
    id_d      = id_q;
    check_d   = check_q;
    head_d    = head_q;
    buttons_d = buttons_q;
    view_x_d  = view_x_q;
    view_y_d  = view_y_q;
    status    = ST_NONE;

    if (item_i.command == CMD_TIMEOUT) begin
      if (phase_q != PH_HUNT) begin
        phase_d = PH_HUNT;
        status  = ST_TIMEOUT;
      end
    end else begin
      case (phase_q)
        PH_HUNT: begin
          if (rx == start_byte_q) begin
            phase_d = PH_ID_LO;
            check_d = 8'h00;
            count_d = 4'd0;
            len_d   = 4'd0;
            id_d    = 16'h0000;
            head_d  = '0;
          end
        end
        PH_ID_LO: begin
          id_d    = {8'h00, rx};
          check_d = rx;
          phase_d = PH_ID_HI;
        end
        PH_ID_HI: begin
          id_d    = {rx, id_q[7:0]};
          check_d = check_q ^ rx;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          if (rx > MaxLen) begin
            phase_d = PH_HUNT;
            status  = ST_LEN_ERR;
          end else begin
            len_d   = rx[3:0];
            check_d = check_q ^ rx;
            count_d = 4'd0;
            phase_d = (rx[3:0] == 4'd0) ? PH_SEQ : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          // Only the first four payload bytes are kept.
          if (count_q[3:2] == 2'b00) begin
            head_d[count_q[1:0]] = rx;
          end
          check_d = check_q ^ rx;
          count_d = count_inc;
          if (count_inc >= len_q) begin
            phase_d = PH_SEQ;
          end
        end
        PH_SEQ: begin
          check_d = check_q ^ rx;
          phase_d = PH_CHECK;
        end
        PH_CHECK: begin
          phase_d = PH_HUNT;
          if (rx != check_q) begin
            status = ST_CHECK_ERR;
          end else if (id_q == match_id_q && len_q >= MIN_LATCH_LEN) begin
            buttons_d = {head_q[1], head_q[0]};
            view_x_d  = head_q[2];
            view_y_d  = head_q[3];
            status    = ST_ACCEPTED;
          end else begin
            status = ST_IGNORED;
          end
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  assign result_o.buttons = buttons_d;
  assign result_o.view_x  = $signed(view_x_d);
  assign result_o.view_y  = $signed(view_y_d);
  assign result_o.status  = status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      count_q   <= 4'd0;
      len_q     <= 4'd0;
      id_q      <= 16'h0000;
      check_q   <= 8'h00;
      head_q    <= '0;
      buttons_q <= 16'h0000;
      view_x_q  <= 8'h00;
      view_y_q  <= 8'h00;
    end else if (step_i) begin
      phase_q   <= phase_d;
      count_q   <= count_d;
      len_q     <= len_d;
      id_q      <= id_d;
      check_q   <= check_d;
      head_q    <= head_d;
      buttons_q <= buttons_d;
      view_x_q  <= view_x_d;
      view_y_q  <= view_y_d;
    end
  end

  // Writes to an index outside the register list fall through unused.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_id_q   <= MATCH_ID_RESET;
      start_byte_q <= START_BYTE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MATCH_ID:   match_id_q   <= cfg_data_i;
        REG_START_BYTE: start_byte_q <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/sfr_out_stage.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module sfr_out_stage import sfr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_item_t result_i,
  output logic      free_o,
  sfr_out_if.source out_ch
);

  logic      valid_q;
  out_item_t data_q;

  assign free_o       = !valid_q || out_ch.ready;
  assign out_ch.valid = valid_q;
  assign out_ch.data  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

endmodule

// ===== rtl/serial_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver
// Parses start-byte framed messages with an XOR check byte and latches
// button and view values from configured-id frames with 4+ payload bytes.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction on in_ch is either a received byte or a receive
// timeout. Each one yields exactly one result transaction on out_ch with
// the latched buttons, both view bytes and a status code.
// The item is registered on entry, parsed by the frame state machine and
// written into the result register once that register is free.
// Throughput is one transaction per cycle while out_ch is not stalled;
// the frame state update is a combinational step between the input and
// result registers.
// When out_ch stalls, the result register holds and the input register
// stays ready until it is itself holding an item, so in_ch.ready drops
// only while a stall backs up both registers.
// Reset clears both registers, returns the parser to start-byte hunting,
// zeros the latched values and restores match_id and start_byte.
// Configuration writes through cfg_we_i take effect on the next cycle
// and are meant for times when no transaction is in flight.
// ----------------------------------------------------------------------------
module serial_frame_receiver_top import sfr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  sfr_in_if.sink              in_ch,
  sfr_out_if.source           out_ch,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic      in_valid;
  in_item_t  in_item;
  logic      out_free;
  logic      advance;
  out_item_t result;

  assign advance = in_valid && out_free;

  sfr_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .advance_i (advance),
    .valid_o   (in_valid),
    .item_o    (in_item)
  );

  sfr_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .item_i     (in_item),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .result_o   (result)
  );

  sfr_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (result),
    .free_o   (out_free),
    .out_ch   (out_ch)
  );

endmodule

// ===== rtl/sfr_checker.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver checker
// Port-level assertions on the receiver's channel timing.
// ----------------------------------------------------------------------------
module sfr_checker import sfr_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  // A stalled result must hold its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

  // The input side only backs up behind a stalled output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input not ready without output back pressure");

  // Every accepted transaction is followed by a result on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> ##2 out_valid_i)
    else $error("result missing two cycles after input transaction");

endmodule

bind serial_frame_receiver_top sfr_checker u_sfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_data_i  (out_ch.data)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame receiver testbench
// Sends framed byte streams, noise and receive timeouts into the receiver.
// A parser model inside the testbench predicts the latched values and the
// status of every transaction, and each result is checked against it in
// order. Both channels idle at random, and the result side stalls for long
// stretches so that the receiver backs up its input.
// ----------------------------------------------------------------------------
module tb;
  import sfr_pkg::*;

  localparam int unsigned MAX_LEN      = 8;
  localparam int unsigned HOLD_CYCLES  = 40;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned MAX_REPORTS  = 10;

  // Indexes that decode to no register.
  localparam logic [CfgIdxW-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SPARE_3 = 2'd3;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ID_LO,
    PH_ID_HI,
    PH_LEN,
    PH_PAYLOAD,
    PH_SEQ,
    PH_CHECK
  } parse_ph_e;

  typedef logic [7:0] byte_q_t[$];

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  sfr_in_if  in_ch ();
  sfr_out_if out_ch ();

  serial_frame_receiver_top #(
    .MAX_PAYLOAD(MAX_LEN)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Parser model state and its copy of the registers.
  logic [15:0]       cfg_match;
  logic [7:0]        cfg_start;
  parse_ph_e         ph;
  logic [3:0]        pay_cnt;
  logic [3:0]        pay_len;
  logic [15:0]       frm_id;
  logic [7:0]        xor_acc;
  logic [31:0]       pay_head;
  logic [15:0]       held_buttons;
  logic signed [7:0] held_vx;
  logic signed [7:0] held_vy;

  out_item_t pending_q[$];

  int unsigned n_sent;
  int unsigned n_noise;
  int unsigned n_cfg;
  int unsigned n_err;
  int unsigned status_seen[8];
  int unsigned quiet_cycles;
  bit          src_idle_en;
  bit          snk_idle_en;
  bit          hold_req;

  function automatic int unsigned draw_gap(bit en);
    if (en && $urandom_range(0, 1) == 1) begin
      return $urandom_range(1, 6);
    end
    return 0;
  endfunction

  // Advances the parser model by one transaction and returns its result.
  function automatic out_item_t step_parser(in_item_t it);
    out_item_t res;
    status_e   st;
    logic [7:0] b;
    b = it.rx_byte;
    st = ST_NONE;
    if (it.command == CMD_TIMEOUT) begin
      if (ph != PH_HUNT) begin
        ph = PH_HUNT;
        st = ST_TIMEOUT;
      end
    end else begin
      case (ph)
        PH_HUNT: begin
          if (b == cfg_start) begin
            ph = PH_ID_LO;
            xor_acc = '0;
            pay_cnt = '0;
            pay_len = '0;
            frm_id = '0;
            pay_head = '0;
          end
        end
        PH_ID_LO: begin
          frm_id = {8'h00, b};
          xor_acc = b;
          ph = PH_ID_HI;
        end
        PH_ID_HI: begin
          frm_id[15:8] = b;
          xor_acc ^= b;
          ph = PH_LEN;
        end
        PH_LEN: begin
          if (b > MAX_LEN) begin
            ph = PH_HUNT;
            st = ST_LEN_ERR;
          end else begin
            pay_len = b[3:0];
            xor_acc ^= b;
            pay_cnt = '0;
            ph = (b == 8'd0) ? PH_SEQ : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          // Only the first four payload bytes are kept.
          if (pay_cnt < 4) begin
            pay_head[pay_cnt*8 +: 8] = b;
          end
          xor_acc ^= b;
          pay_cnt = pay_cnt + 4'd1;
          if (pay_cnt >= pay_len) begin
            ph = PH_SEQ;
          end
        end
        PH_SEQ: begin
          xor_acc ^= b;
          ph = PH_CHECK;
        end
        PH_CHECK: begin
          if (b != xor_acc) begin
            st = ST_CHECK_ERR;
          end else if (frm_id == cfg_match && pay_len >= MIN_LATCH_LEN) begin
            held_buttons = pay_head[15:0];
            held_vx = pay_head[23:16];
            held_vy = pay_head[31:24];
            st = ST_ACCEPTED;
          end else begin
            st = ST_IGNORED;
          end
          ph = PH_HUNT;
        end
        default: ph = PH_HUNT;
      endcase
    end
    res.buttons = held_buttons;
    res.view_x = held_vx;
    res.view_y = held_vy;
    res.status = st;
    return res;
  endfunction

  task automatic send_item(logic cmd, logic [7:0] b);
    in_item_t    it;
    int unsigned gap;
    it.command = cmd;
    it.rx_byte = b;
    gap = draw_gap(src_idle_en);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_q.push_back(step_parser(it));
    n_sent++;
  endtask

  // Sends one frame. A nonzero chk_flip corrupts the check byte; a positive
  // cut_at keeps only that many bytes and then abandons the frame by timeout.
  task automatic send_frame(logic [15:0] id, logic [7:0] len, byte_q_t body,
                            logic [7:0] seq, logic [7:0] chk_flip, int cut_at);
    byte_q_t    fb;
    logic [7:0] chk;
    chk = id[7:0] ^ id[15:8] ^ len ^ seq;
    foreach (body[i]) chk ^= body[i];
    if (ph != PH_HUNT) begin
      send_item(CMD_TIMEOUT, 8'($urandom));
    end
    fb.push_back(cfg_start);
    fb.push_back(id[7:0]);
    fb.push_back(id[15:8]);
    fb.push_back(len);
    if (len <= MAX_LEN) begin
      foreach (body[i]) fb.push_back(body[i]);
      fb.push_back(seq);
      fb.push_back(chk ^ chk_flip);
    end
    if (cut_at > 0) begin
      while (fb.size() > cut_at) void'(fb.pop_back());
    end
    foreach (fb[i]) send_item(CMD_BYTE, fb[i]);
    if (cut_at > 0) begin
      send_item(CMD_TIMEOUT, 8'($urandom));
    end
  endtask

  function automatic byte_q_t random_body(int unsigned len);
    byte_q_t body;
    for (int i = 0; i < len; i++) begin
      // Start bytes inside a frame must be taken as data.
      body.push_back(($urandom_range(0, 7) == 0) ? cfg_start : 8'($urandom));
    end
    return body;
  endfunction

  task automatic send_random_frame();
    int unsigned pick;
    logic [15:0] id;
    logic [7:0]  len;
    logic [7:0]  b;
    byte_q_t     body;
    pick = $urandom_range(0, 99);
    id = cfg_match;
    len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, MAX_LEN))
                                      : 8'($urandom_range(MIN_LATCH_LEN, MAX_LEN));
    if (pick >= 55 && pick < 70) begin
      id = 16'($urandom);
    end
    if (pick >= 80 && pick < 88) begin
      len = 8'($urandom_range(MAX_LEN + 1, 255));
    end
    if (len <= MAX_LEN) begin
      body = random_body(len);
    end
    if (pick < 70) begin
      send_frame(id, len, body, 8'($urandom), 8'h00, 0);
    end else if (pick < 80) begin
      send_frame(id, len, body, 8'($urandom), 8'($urandom_range(1, 255)), 0);
    end else if (pick < 88) begin
      send_frame(id, len, body, 8'($urandom), 8'h00, 0);
    end else if (pick < 96) begin
      send_frame(id, len, body, 8'($urandom), 8'h00, $urandom_range(1, len + 5));
    end else begin
      repeat ($urandom_range(1, 3)) begin
        b = 8'($urandom);
        if (b == cfg_start) begin
          b = ~b;
        end
        send_item(CMD_BYTE, b);
        n_noise++;
      end
      if ($urandom_range(0, 1) == 1) begin
        send_item(CMD_TIMEOUT, 8'($urandom));
        n_noise++;
      end
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MATCH_ID:   cfg_match = val;
      REG_START_BYTE: cfg_start = val[7:0];
      default: ;
    endcase
    n_cfg++;
    @(posedge clk_i);
  endtask

  task automatic test_hunting();
    send_item(CMD_TIMEOUT, 8'h00);
    send_item(CMD_TIMEOUT, 8'hFF);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'hFF);
  endtask

  task automatic test_accepted_frame();
    byte_q_t body;
    body = '{8'hFF, 8'hFF, 8'h80, 8'h7F};
    // The sequence byte equals the start byte and must not reopen a frame.
    send_frame(cfg_match, 8'd4, body, cfg_start, 8'h00, 0);
  endtask

  task automatic test_length_error();
    byte_q_t body;
    send_frame(cfg_match, 8'hFF, body, 8'h00, 8'h00, 0);
  endtask

  task automatic test_zero_length();
    byte_q_t body;
    send_frame(cfg_match, 8'd0, body, 8'h00, 8'h00, 0);
  endtask

  task automatic test_check_error();
    byte_q_t body;
    send_frame(16'hFFFF, 8'd0, body, 8'h5A, 8'h01, 0);
  endtask

  task automatic test_timeout_abort();
    byte_q_t body;
    body = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_frame(cfg_match, 8'd4, body, 8'h00, 8'h00, 2);
  endtask

  task automatic test_random_frames(int unsigned target);
    int unsigned base;
    int unsigned mark;
    base = n_sent - n_noise;
    mark = 0;
    while (n_sent - n_noise - base < target) begin
      if (n_sent - mark >= 64) begin
        mark = n_sent;
        {src_idle_en, snk_idle_en} = 2'($urandom_range(0, 3));
      end
      send_random_frame();
    end
  endtask

  task automatic test_config_sweep();
    logic [15:0] id_set[4];
    logic [7:0]  sb_set[4];
    id_set = '{16'h0000, 16'hFFFF, 16'($urandom), MATCH_ID_RESET};
    sb_set = '{8'h00, 8'hFF, 8'($urandom), START_BYTE_RESET};
    for (int s = 0; s < 4; s++) begin
      wait_idle();
      write_reg(REG_MATCH_ID, id_set[s]);
      write_reg(REG_START_BYTE, {8'($urandom), sb_set[s]});
      if (s == 2) begin
        write_reg(REG_SPARE_2, 16'($urandom));
        write_reg(REG_SPARE_3, 16'($urandom));
      end
      test_random_frames(130);
    end
  endtask

  task automatic test_backpressure();
    repeat (2) begin
      src_idle_en = 1'b0;
      snk_idle_en = 1'b0;
      hold_req = 1'b1;
      test_random_frames(60);
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_ch.ready <= 1'b1;
        hold_req = 1'b0;
      end else if (out_ch.valid && out_ch.ready) begin
        stall = draw_gap(snk_idle_en);
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    out_item_t got;
    if (out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      status_seen[got.status]++;
      if (pending_q.size() == 0) begin
        n_err++;
        if (n_err <= MAX_REPORTS) begin
          $display("unexpected result: buttons=%h x=%0d y=%0d status=%0d",
                   got.buttons, got.view_x, got.view_y, got.status);
        end
      end else begin
        want = pending_q.pop_front();
        if (got.buttons !== want.buttons || got.view_x !== want.view_x ||
            got.view_y !== want.view_y || got.status !== want.status) begin
          n_err++;
          if (n_err <= MAX_REPORTS) begin
            $display("mismatch: expected buttons=%h x=%0d y=%0d status=%0d",
                     want.buttons, want.view_x, want.view_y, want.status);
            $display("          got      buttons=%h x=%0d y=%0d status=%0d",
                     got.buttons, got.view_x, got.view_y, got.status);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("serial_frame_receiver_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    cfg_match = MATCH_ID_RESET;
    cfg_start = START_BYTE_RESET;
    ph = PH_HUNT;
    pay_cnt = '0;
    pay_len = '0;
    frm_id = '0;
    xor_acc = '0;
    pay_head = '0;
    held_buttons = '0;
    held_vx = '0;
    held_vy = '0;
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    hold_req = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_hunting();
    test_accepted_frame();
    test_length_error();
    test_zero_length();
    test_check_error();
    test_timeout_abort();
    test_random_frames(400);
    test_config_sweep();
    test_backpressure();

    wait_idle();
    n_err += pending_q.size();
    $display("sent %0d transactions across %0d register writes", n_sent, n_cfg);
    $display("statuses: %0d accepted, %0d check error, %0d length error, %0d ignored, %0d timeout",
             status_seen[ST_ACCEPTED], status_seen[ST_CHECK_ERR], status_seen[ST_LEN_ERR],
             status_seen[ST_IGNORED], status_seen[ST_TIMEOUT]);
    if (n_err == 0) begin
      $display("serial_frame_receiver_top regression: pass");
    end else begin
      $display("serial_frame_receiver_top regression: fail");
    end
    $finish;
  end

endmodule
